@@ hdl/opl_pkg.sv @@
// Shared types, codes and field widths for the ordered position list.
`timescale 1ns / 1ps

package opl_pkg;

    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_READ   = 3'd3,
        OP_SEARCH = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;   // open a slot at the target and write the new value there
        logic rem;   // close the slot at the target
        logic srch;  // probe looks for a value instead of a position
    } cell_ctl_t;

endpackage

@@ hdl/opl_cell.sv @@
// One list entry with its shift logic and one stage of the probe chain.
`timescale 1ns / 1ps

module opl_cell import opl_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CMP_W      = 6,
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cell_ctl_t             ctl,
    input  logic [CMP_W-1:0]      tgt,
    input  logic [CMP_W-1:0]      cnt,
    input  logic [DATA_WIDTH-1:0] din,
    input  logic [DATA_WIDTH-1:0] prev_data,
    input  logic [DATA_WIDTH-1:0] next_data,
    output logic [DATA_WIDTH-1:0] data,
    input  logic                  pin_valid,
    input  logic                  pin_hit,
    input  logic [DATA_WIDTH-1:0] pin_data,
    input  logic [CMP_W-1:0]      pin_found,
    output logic                  pout_valid,
    output logic                  pout_hit,
    output logic [DATA_WIDTH-1:0] pout_data,
    output logic [CMP_W-1:0]      pout_found
);

    localparam logic [CMP_W-1:0] IDX    = CMP_W'(INDEX);
    localparam logic [CMP_W-1:0] IDX_P1 = CMP_W'(INDEX + 1);

    logic [DATA_WIDTH-1:0] data_reg;
    logic                  pv_reg;
    logic                  ph_reg;
    logic [DATA_WIDTH-1:0] pd_reg;
    logic [CMP_W-1:0]      pf_reg;
    logic                  occ;
    logic                  match;

    assign occ   = IDX < cnt;
    assign match = ctl.srch ? (occ && (data_reg == din)) : (IDX == tgt);

    // Entry storage: shift up on insert, down on remove.
    always_ff @(posedge aclk) begin
        if (ctl.ins) begin
            if (IDX > tgt) begin
                data_reg <= prev_data;
            end else if (IDX == tgt) begin
                data_reg <= din;
            end
        end else if (ctl.rem) begin
            if (IDX >= tgt) begin
                data_reg <= next_data;
            end
        end
    end

    // Probe stage: the first cell that matches stamps its result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= pin_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pin_valid && !pin_hit && match) begin
            ph_reg <= 1'b1;
            if (ctl.srch) begin
                pd_reg <= pin_data;
                pf_reg <= IDX_P1;
            end else begin
                pd_reg <= data_reg;
                pf_reg <= pin_found;
            end
        end else begin
            ph_reg <= pin_hit;
            pd_reg <= pin_data;
            pf_reg <= pin_found;
        end
    end

    assign data       = data_reg;
    assign pout_valid = pv_reg;
    assign pout_hit   = ph_reg;
    assign pout_data  = pd_reg;
    assign pout_found = pf_reg;

endmodule

@@ hdl/ordered_position_list.sv @@
// Top level of the ordered position list: request decode, cell chain, result register.
`timescale 1ns / 1ps
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | operation, position, value (40 bits)
//  m_      | out | m_tvalid/m_tready  | status, read_value, found_position,
//          |     |                    | list_length (44 bits, padded to 48)
//
//  Append, insert, remove, clear and rejected requests write their result straight
//  into the result register: every cell compares its index to the target and shifts or writes at once.
//  Read and search send a probe down the chain of CAPACITY cells, one cell a
//  cycle, and the probe leaving the last cell fills the result register.
//  Reset clears the length and the control state; entries hold anything until
//  written. A new item is taken only when idle and the result register is free
//  or being emptied in the same cycle; a stalled result holds in m_tdata.

module ordered_position_list import opl_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operation[2:0], position[7:3], value[39:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], read_value[33:2],
                                   // found_position[38:34], list_length[43:39]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);
    localparam logic [CMP_W-1:0] ONE_C = CMP_W'(1);

    typedef enum logic {
        S_IDLE,
        S_SWEEP
    } state_t;

    state_t state_reg;

    // Unpack the request.
    logic [OP_W-1:0]  in_op;
    logic [POS_W-1:0] in_pos;
    logic [VAL_W-1:0] in_val;

    assign in_op  = s_tdata[2:0];
    assign in_pos = s_tdata[7:3];
    assign in_val = s_tdata[39:8];

    logic accept;
    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid || m_tready);
    assign accept   = s_tvalid && s_tready;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CMP_W-1:0] cnt_c;
    logic [CMP_W-1:0] pos_c;

    assign cnt_c = CMP_W'(count_reg);
    assign pos_c = CMP_W'(in_pos);

    // Request decode: status, shift command, target index.
    status_t          dec_status;
    logic             dec_ins;
    logic             dec_rem;
    logic             dec_sweep;
    logic             dec_srch;
    logic             dec_clr;
    logic [CMP_W-1:0] dec_tgt;

    always_comb begin
        dec_status = ST_OK;
        dec_ins    = 1'b0;
        dec_rem    = 1'b0;
        dec_sweep  = 1'b0;
        dec_srch   = 1'b0;
        dec_clr    = 1'b0;
        dec_tgt    = pos_c - ONE_C;
        unique case (in_op)
            OP_APPEND: begin
                dec_tgt = cnt_c;
                if (cnt_c >= CAP_C) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_ins = 1'b1;
                end
            end
            OP_INSERT: begin
                if (cnt_c >= CAP_C) begin
                    dec_status = ST_FULL;
                end else if (pos_c == '0 || pos_c > cnt_c + ONE_C) begin
                    dec_status = ST_BAD_POS;
                end else begin
                    dec_ins = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (cnt_c == '0) begin
                    dec_status = ST_EMPTY;
                end else if (pos_c == '0 || pos_c > cnt_c) begin
                    dec_status = ST_BAD_POS;
                end else begin
                    dec_rem = 1'b1;
                end
            end
            OP_READ: begin
                if (cnt_c == '0) begin
                    dec_status = ST_EMPTY;
                end else if (pos_c == '0 || pos_c > cnt_c) begin
                    dec_status = ST_BAD_POS;
                end else begin
                    dec_sweep = 1'b1;
                end
            end
            OP_SEARCH: begin
                dec_sweep = 1'b1;
                dec_srch  = 1'b1;
            end
            OP_CLEAR: begin
                dec_clr = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (dec_clr) begin
            count_next = '0;
        end else if (dec_ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (dec_rem) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Hold the request fields for the length of a probe sweep.
    logic                  srch_reg;
    logic [CMP_W-1:0]      tgt_reg;
    logic [DATA_WIDTH-1:0] val_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            srch_reg <= dec_srch;
            tgt_reg  <= dec_tgt;
            val_reg  <= DATA_WIDTH'(in_val);
        end
    end

    // Broadcast to the cells: live request on the accept cycle, the registered copy after it.
    cell_ctl_t             ctl;
    logic [CMP_W-1:0]      tgt_cur;
    logic [DATA_WIDTH-1:0] val_cur;

    assign ctl.ins  = accept && dec_ins;
    assign ctl.rem  = accept && dec_rem;
    assign ctl.srch = accept ? dec_srch : srch_reg;
    assign tgt_cur  = accept ? dec_tgt : tgt_reg;
    assign val_cur  = accept ? DATA_WIDTH'(in_val) : val_reg;

    // Cell chain.
    logic [DATA_WIDTH-1:0] ent_w   [CAPACITY];
    logic [DATA_WIDTH-1:0] prev_w  [CAPACITY];
    logic [DATA_WIDTH-1:0] next_w  [CAPACITY];
    logic                  pv_w    [CAPACITY];
    logic                  ph_w    [CAPACITY];
    logic [DATA_WIDTH-1:0] pd_w    [CAPACITY];
    logic [CMP_W-1:0]      pf_w    [CAPACITY];
    logic                  piv_w   [CAPACITY];
    logic                  pih_w   [CAPACITY];
    logic [DATA_WIDTH-1:0] pid_w   [CAPACITY];
    logic [CMP_W-1:0]      pif_w   [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            // Inject a fresh probe with no hit.
            assign prev_w[g] = '0;
            assign piv_w[g]  = accept && dec_sweep;
            assign pih_w[g]  = 1'b0;
            assign pid_w[g]  = '0;
            assign pif_w[g]  = '0;
        end else begin : g_link
            assign prev_w[g] = ent_w[g-1];
            assign piv_w[g]  = pv_w[g-1];
            assign pih_w[g]  = ph_w[g-1];
            assign pid_w[g]  = pd_w[g-1];
            assign pif_w[g]  = pf_w[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign next_w[g] = '0;
        end else begin : g_mid
            assign next_w[g] = ent_w[g+1];
        end

        opl_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CMP_W      (CMP_W),
            .INDEX      (g)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .tgt        (tgt_cur),
            .cnt        (cnt_c),
            .din        (val_cur),
            .prev_data  (prev_w[g]),
            .next_data  (next_w[g]),
            .data       (ent_w[g]),
            .pin_valid  (piv_w[g]),
            .pin_hit    (pih_w[g]),
            .pin_data   (pid_w[g]),
            .pin_found  (pif_w[g]),
            .pout_valid (pv_w[g]),
            .pout_hit   (ph_w[g]),
            .pout_data  (pd_w[g]),
            .pout_found (pf_w[g])
        );
    end

    logic                  last_pv;
    logic [DATA_WIDTH-1:0] last_pd;
    logic [CMP_W-1:0]      last_pf;

    assign last_pv = pv_w[CAPACITY-1];
    assign last_pd = pd_w[CAPACITY-1];
    assign last_pf = pf_w[CAPACITY-1];

    // State, length and result register.
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        count_reg <= count_next;
                        if (dec_sweep) begin
                            // Any waiting result leaves on this edge; hold empty.
                            state_reg    <= S_SWEEP;
                            m_tvalid_reg <= 1'b0;
                        end else begin
                            // Finish at once: no read data, no position.
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= {4'b0, LEN_W'(count_next), {POS_W{1'b0}},
                                             {VAL_W{1'b0}}, dec_status};
                        end
                    end else if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                end
                S_SWEEP: begin
                    if (last_pv) begin
                        state_reg    <= S_IDLE;
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'b0, LEN_W'(count_reg),
                                         srch_reg ? POS_W'(last_pf) : {POS_W{1'b0}},
                                         srch_reg ? {VAL_W{1'b0}} : VAL_W'(last_pd),
                                         ST_OK};
                    end else if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CAP_C)
        else $error("list length beyond capacity");

    a_sweep_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SWEEP) |-> !m_tvalid_reg)
        else $error("result register busy during probe sweep");

    a_probe_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        last_pv |-> (state_reg == S_SWEEP))
        else $error("probe left the chain outside a sweep");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_op == OP_APPEND && cnt_c < CAP_C)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append did not grow the list");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the ordered position list: directed edge cases, then random traffic.
`timescale 1ns / 1ps

module tb_top;
    import opl_pkg::*;

    localparam int CAP            = CAPACITY_DEF;
    localparam int DW             = DATA_WIDTH_DEF;
    localparam int RANDOM_ITEMS   = 1320;
    localparam int IDLE_PCT       = 36;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_ITEM   = 900;
    localparam int DRAIN_CYCLES   = 2 * CAP + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // Opcodes the block must treat as no-ops.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef enum int {DRIFT_GROW, DRIFT_SHRINK, DRIFT_MIXED} drift_t;

    typedef struct packed {
        status_t            status;
        logic [VAL_W-1:0]   read_value;
        logic [LEN_W-1:0]   found_pos;
        logic [LEN_W-1:0]   length;
    } list_result_t;

    // Shadow list plus the queue of results still owed by the block.
    class list_scoreboard;
        logic [DW-1:0]  cells [CAP];
        int             depth;
        list_result_t   owed_q [$];
        int unsigned    errors;
        int unsigned    results_seen;
        int unsigned    full_refusals;
        int unsigned    empty_refusals;
        int unsigned    op_hits [8];

        function new();
            depth = 0;
            errors = 0;
            results_seen = 0;
            full_refusals = 0;
            empty_refusals = 0;
            foreach (op_hits[i]) op_hits[i] = 0;
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction

        // Apply one accepted request to the shadow list and queue its result.
        function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                   logic [VAL_W-1:0] val);
            list_result_t r;
            int p;
            int k;
            r = '0;
            r.status = ST_OK;
            p = int'(pos);
            op_hits[op]++;
            case (op)
                OP_APPEND: begin
                    if (depth >= CAP) begin
                        r.status = ST_FULL;
                    end else begin
                        cells[depth] = val[DW-1:0];
                        depth++;
                    end
                end
                OP_INSERT: begin
                    if (depth >= CAP) begin
                        r.status = ST_FULL;
                    end else if (p < 1 || p > depth + 1) begin
                        r.status = ST_BAD_POS;
                    end else begin
                        for (k = depth; k >= p; k--) cells[k] = cells[k-1];
                        cells[p-1] = val[DW-1:0];
                        depth++;
                    end
                end
                OP_REMOVE: begin
                    if (depth == 0) begin
                        r.status = ST_EMPTY;
                    end else if (p < 1 || p > depth) begin
                        r.status = ST_BAD_POS;
                    end else begin
                        for (k = p; k < depth; k++) cells[k-1] = cells[k];
                        depth--;
                    end
                end
                OP_READ: begin
                    if (depth == 0) begin
                        r.status = ST_EMPTY;
                    end else if (p < 1 || p > depth) begin
                        r.status = ST_BAD_POS;
                    end else begin
                        r.read_value = VAL_W'(cells[p-1]);
                    end
                end
                OP_SEARCH: begin
                    for (k = 0; k < depth; k++) begin
                        if (cells[k] == val[DW-1:0]) begin
                            r.found_pos = LEN_W'(k + 1);
                            break;
                        end
                    end
                end
                OP_CLEAR: begin
                    depth = 0;
                end
                default: begin
                end
            endcase
            if (r.status == ST_FULL) full_refusals++;
            if (r.status == ST_EMPTY) empty_refusals++;
            r.length = LEN_W'(depth);
            owed_q.push_back(r);
        endfunction

        // Compare one accepted result word against the oldest owed result.
        function void check_result(logic [47:0] word);
            list_result_t want;
            list_result_t got;
            got.status     = status_t'(word[1:0]);
            got.read_value = word[33:2];
            got.found_pos  = word[38:34];
            got.length     = word[43:39];
            results_seen++;
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("[%0t] result %0d arrived with nothing owed: %h",
                             $realtime, results_seen, word);
                return;
            end
            want = owed_q.pop_front();
            if (got.status !== want.status || got.read_value !== want.read_value ||
                got.found_pos !== want.found_pos || got.length !== want.length) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"[%0t] result %0d mismatch: expected status %0d read %h ",
                              "found %0d length %0d, got status %0d read %h found %0d ",
                              "length %0d"}, $realtime, results_seen,
                             want.status, want.read_value, want.found_pos, want.length,
                             got.status, got.read_value, got.found_pos, got.length);
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [39:0]        s_tdata;    // operation[2:0], position[7:3], value[39:8]
    logic               m_tvalid;
    logic               m_tready;
    logic [47:0]        m_tdata;    // status[1:0], read_value[33:2],
                                    // found_position[38:34], list_length[43:39]

    list_scoreboard     sb;
    int unsigned        items_sent = 0;
    bit                 calm = 1'b0;
    int unsigned        stall_cycles = 0;
    logic [VAL_W-1:0]   value_pool [8];

    ordered_position_list #(
        .CAPACITY   (CAP),
        .DATA_WIDTH (DW)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    // Offer one item, idling first at random, and hold it until accepted.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] val);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, pos, op};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, pos, val);
        items_sent++;
    endtask

    // Walk the empty list, fill it to capacity, probe both ends, then clear.
    task automatic run_directed();
        int k;
        send_item(OP_READ,   5'd1,  '0);               // read on empty list
        send_item(OP_REMOVE, 5'd1,  '0);               // remove on empty list
        send_item(OP_SEARCH, 5'd0,  32'hFFFF_FFFF);    // search on empty list
        send_item(OP_INSERT, 5'd0,  32'h0000_0001);    // position zero
        send_item(OP_INSERT, 5'd2,  32'h0000_0002);    // past length plus one
        send_item(OP_INSERT, 5'd1,  32'hFFFF_FFFF);
        for (k = 1; k < CAP; k++)
            send_item(OP_APPEND, 5'd31, 32'((k - 1) * 32'h0111_1111));
        send_item(OP_APPEND, 5'd0,  32'hA5A5_A5A5);    // full list
        send_item(OP_INSERT, 5'd31, 32'h5A5A_5A5A);    // fullness wins over position
        send_item(OP_READ,   5'(CAP), '0);             // last entry
        send_item(OP_READ,   5'(CAP + 1), '0);         // one past the end
        send_item(OP_SEARCH, 5'd0,  32'h0000_0000);
        send_item(OP_SEARCH, 5'd0,  32'hDEAD_BEEF);    // absent value
        send_item(OP_REMOVE, 5'(CAP), '0);
        send_item(OP_INSERT, 5'(CAP), 32'h8000_0000);  // insert at length plus one
        send_item(OP_REMOVE, 5'd1,  '0);
        send_item(OP_READ,   5'd0,  '0);
        send_item(OP_SPARE_LO, 5'd31, 32'hFFFF_FFFF);
        send_item(OP_SPARE_HI, 5'd0,  32'h0000_0000);
        send_item(OP_CLEAR,  5'd7,  32'h5555_5555);
        send_item(OP_SEARCH, 5'd0,  32'h0000_0000);    // stale entries stay hidden
        send_item(OP_READ,   5'd1,  '0);
    endtask

    // Draw one request; the drift biases the list toward full or empty.
    task automatic send_random_item(input drift_t drift);
        int roll;
        int d;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        d = sb.depth;
        roll = $urandom_range(0, 99);
        if (roll < ((drift == DRIFT_SHRINK) ? 4 : 1)) begin
            op = OP_CLEAR;
        end else if (roll < ((drift == DRIFT_SHRINK) ? 6 : 3)) begin
            op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
        end else begin
            roll = $urandom_range(0, 99);
            case (drift)
                DRIFT_GROW:   op = (roll < 35) ? OP_APPEND : (roll < 65) ? OP_INSERT :
                                   (roll < 75) ? OP_REMOVE : (roll < 87) ? OP_READ :
                                   OP_SEARCH;
                DRIFT_SHRINK: op = (roll < 8)  ? OP_APPEND : (roll < 16) ? OP_INSERT :
                                   (roll < 56) ? OP_REMOVE : (roll < 78) ? OP_READ :
                                   OP_SEARCH;
                default:      op = (roll < 18) ? OP_APPEND : (roll < 36) ? OP_INSERT :
                                   (roll < 58) ? OP_REMOVE : (roll < 80) ? OP_READ :
                                   OP_SEARCH;
            endcase
        end

        // Mostly legal positions, the rest anywhere in the field.
        pos = POS_W'($urandom_range(0, 31));
        if (op == OP_INSERT && $urandom_range(0, 99) < 85)
            pos = POS_W'($urandom_range(1, d + 1));
        else if ((op == OP_REMOVE || op == OP_READ) && d > 0 && $urandom_range(0, 99) < 85)
            pos = POS_W'($urandom_range(1, d));

        roll = $urandom_range(0, 99);
        if (op == OP_SEARCH && d > 0 && roll < 70)
            val = VAL_W'(sb.cells[$urandom_range(0, d - 1)]);
        else if (roll < 50)
            val = value_pool[$urandom_range(0, 7)];
        else if (roll < 60)
            val = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        else
            val = $urandom;
        send_item(op, pos, val);
    endtask

    // Result sink: random backpressure, one long hold-off to fill the block.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
                m_tready <= 1'b0;
                hold_left = HOLD_CYCLES - 1;
                hold_done = 1'b1;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Check every result at the edge it is taken.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Abort when neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles, %0d results owed",
                     $realtime, stall_cycles, sb.outstanding());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        int i;
        drift_t drift;
        sb = new();
        drift = DRIFT_MIXED;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        foreach (value_pool[j]) value_pool[j] = $urandom;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        // Switch drift every 50 items; run one window with no idling at all.
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0) drift = drift_t'($urandom_range(0, 2));
            calm = (i >= 500 && i < 700);
            send_random_item(drift);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // Drain owed results, then let any stray result show up.
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.errors += sb.outstanding();

        $display({"covered %0d requests: append %0d, insert %0d, remove %0d, read %0d, ",
                  "search %0d, clear %0d, spare opcodes %0d"}, items_sent,
                 sb.op_hits[OP_APPEND], sb.op_hits[OP_INSERT], sb.op_hits[OP_REMOVE],
                 sb.op_hits[OP_READ], sb.op_hits[OP_SEARCH], sb.op_hits[OP_CLEAR],
                 sb.op_hits[OP_SPARE_LO] + sb.op_hits[OP_SPARE_HI]);
        $display("%0d results checked, %0d full-list refusals, %0d empty-list refusals, %0d errors",
                 sb.results_seen, sb.full_refusals, sb.empty_refusals, sb.errors);
        if (sb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
